// ===== hdl/kvt_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kvt_pkg
// Shared codes and types for the keyed reference value table.
// -----------------------------------------------------------------------------
package kvt_pkg;

   localparam int REQ_BITS   = 104;
   localparam int RSP_BITS   = 104;
   localparam int VALUE_BITS = 64;

   localparam logic [2:0] OP_GET   = 3'd0;
   localparam logic [2:0] OP_SET   = 3'd1;
   localparam logic [2:0] OP_CLEAR = 3'd2;
   localparam logic [2:0] OP_ALLOC = 3'd3;
   localparam logic [2:0] OP_GOS   = 3'd4;

   localparam logic [3:0] ST_IGNORED     = 4'd0;
   localparam logic [3:0] ST_RETURNED    = 4'd1;
   localparam logic [3:0] ST_NOT_SET     = 4'd2;
   localparam logic [3:0] ST_NONEXISTENT = 4'd3;
   localparam logic [3:0] ST_STORED      = 4'd4;
   localparam logic [3:0] ST_FULL        = 4'd5;
   localparam logic [3:0] ST_TOO_LARGE   = 4'd6;
   localparam logic [3:0] ST_ALLOCATED   = 4'd7;
   localparam logic [3:0] ST_CLEARED     = 4'd8;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // search beat traveling down the cell row
   typedef struct packed {
      logic       valid;
      logic [2:0] op;
      logic       hit;
      logic       hit_set;
   } wave_ctl_type;

   // write and clear broadcast to every cell
   typedef struct packed {
      logic wr_en;
      logic wr_set;
      logic clr;
   } bcast_ctl_type;

endpackage

// ===== hdl/kvt_cell.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kvt_cell
// One table entry: key, value and set flag, plus one stage of the search row.
// -----------------------------------------------------------------------------
module kvt_cell
   import kvt_pkg::*;
#(
   parameter int KEY_BITS = 32,
   parameter int CW       = 7,
   parameter int IDX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wave_ctl_type          in_ctl,
   input  logic [KEY_BITS-1:0]   in_key,
   input  logic [VALUE_BITS-1:0] in_val,
   input  logic [VALUE_BITS-1:0] in_hval,
   output wave_ctl_type          out_ctl,
   output logic [KEY_BITS-1:0]   out_key,
   output logic [VALUE_BITS-1:0] out_val,
   output logic [VALUE_BITS-1:0] out_hval,
   input  logic [CW-1:0]         count,
   input  bcast_ctl_type         bc_ctl,
   input  logic [CW-1:0]         bc_idx,
   input  logic [KEY_BITS-1:0]   bc_key,
   input  logic [VALUE_BITS-1:0] bc_val
);

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  set_ff, set_in;
   wave_ctl_type          out_ctl_ff, out_ctl_in;
   logic [KEY_BITS-1:0]   out_key_ff;
   logic [VALUE_BITS-1:0] out_val_ff;
   logic [VALUE_BITS-1:0] out_hval_ff, out_hval_in;
   logic                  match;
   logic                  update;
   logic                  bc_hit;

   always_comb begin
      match  = in_ctl.valid && (CW'(IDX) < count) && (key_ff == in_key);
      update = match && ((in_ctl.op == OP_SET) || ((in_ctl.op == OP_GOS) && !set_ff));
      bc_hit = bc_ctl.wr_en && (bc_idx == CW'(IDX));

      out_ctl_in  = in_ctl;
      out_hval_in = in_hval;
      if (match) begin
         out_ctl_in.hit     = 1'b1;
         out_ctl_in.hit_set = set_ff;
         out_hval_in        = value_ff;
      end

      key_in   = key_ff;
      value_in = value_ff;
      set_in   = set_ff;
      if (bc_ctl.clr) begin
         set_in = 1'b0;
      end
      if (update) begin
         value_in = in_val;
         set_in   = 1'b1;
      end
      if (bc_hit) begin
         key_in   = bc_key;
         value_in = bc_val;
         set_in   = bc_ctl.wr_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff     <= 1'b0;
         out_ctl_ff <= '0;
      end else begin
         set_ff     <= set_in;
         out_ctl_ff <= out_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      value_ff    <= value_in;
      out_key_ff  <= in_key;
      out_val_ff  <= in_val;
      out_hval_ff <= out_hval_in;
   end

   assign out_ctl  = out_ctl_ff;
   assign out_key  = out_key_ff;
   assign out_val  = out_val_ff;
   assign out_hval = out_hval_ff;

endmodule

// ===== hdl/kvt_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kvt_ctrl
// Request decode, search launch, append, allocate and clear, and result register.
// -----------------------------------------------------------------------------
module kvt_ctrl
   import kvt_pkg::*;
#(
   parameter int ENTRIES  = 64,
   parameter int KEY_BITS = 32,
   parameter int CW       = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_BITS-1:0]   req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_BITS-1:0]   rsp_tdata,
   output wave_ctl_type          wave_ctl,
   output logic [KEY_BITS-1:0]   wave_key,
   output logic [VALUE_BITS-1:0] wave_val,
   input  wave_ctl_type          ret_ctl,
   input  logic [KEY_BITS-1:0]   ret_key,
   input  logic [VALUE_BITS-1:0] ret_val,
   input  logic [VALUE_BITS-1:0] ret_hval,
   output logic [CW-1:0]         count,
   output bcast_ctl_type         bc_ctl,
   output logic [CW-1:0]         bc_idx,
   output logic [KEY_BITS-1:0]   bc_key,
   output logic [VALUE_BITS-1:0] bc_val
);

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [KEY_BITS-1:0]   next_key_ff, next_key_in;
   wave_ctl_type          wave_ctl_ff, wave_ctl_in;
   logic [KEY_BITS-1:0]   wave_key_ff, wave_key_in;
   logic [VALUE_BITS-1:0] wave_val_ff, wave_val_in;
   bcast_ctl_type         bc_ctl_ff, bc_ctl_in;
   logic [CW-1:0]         bc_idx_ff, bc_idx_in;
   logic [KEY_BITS-1:0]   bc_key_ff, bc_key_in;
   logic [VALUE_BITS-1:0] bc_val_ff, bc_val_in;
   logic [3:0]            res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0] res_value_ff, res_value_in;
   logic [31:0]           res_key_ff, res_key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [3:0]            rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [31:0]           rsp_key_ff, rsp_key_in;

   logic [2:0]            req_op;
   logic [KEY_BITS-1:0]   req_key;
   logic [VALUE_BITS-1:0] req_val;
   logic                  full;

   always_comb begin
      req_op  = req_tdata[2:0];
      req_key = KEY_BITS'(req_tdata[34:3]);
      req_val = req_tdata[98:35];
      full    = (count_ff == CW'(ENTRIES));

      state_in      = state_ff;
      count_in      = count_ff;
      next_key_in   = next_key_ff;
      wave_ctl_in   = '0;
      wave_key_in   = wave_key_ff;
      wave_val_in   = wave_val_ff;
      bc_ctl_in     = '0;
      bc_idx_in     = bc_idx_ff;
      bc_key_in     = bc_key_ff;
      bc_val_in     = bc_val_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_key_in    = res_key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_key_in    = rsp_key_ff;
      req_tready    = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in      = S_DONE;
               res_status_in = ST_IGNORED;
               res_value_in  = '0;
               res_key_in    = '0;
               case (req_op)
                  OP_GET, OP_SET, OP_GOS: begin
                     if (req_key == '0) begin
                        if (req_op == OP_GOS) begin
                           res_value_in = req_val;
                        end
                     end else begin
                        wave_ctl_in.valid = 1'b1;
                        wave_ctl_in.op    = req_op;
                        wave_key_in       = req_key;
                        wave_val_in       = req_val;
                        state_in          = S_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     bc_ctl_in.clr = 1'b1;
                     res_status_in = ST_CLEARED;
                  end
                  OP_ALLOC: begin
                     if (full || !next_key_ff[KEY_BITS-1]) begin
                        res_status_in = ST_FULL;
                     end else begin
                        bc_ctl_in.wr_en  = 1'b1;
                        bc_ctl_in.wr_set = 1'b0;
                        bc_idx_in        = count_ff;
                        bc_key_in        = next_key_ff;
                        bc_val_in        = '0;
                        count_in         = count_ff + 1'b1;
                        res_key_in       = 32'(next_key_ff);
                        next_key_in      = next_key_ff - 1'b1;
                        res_status_in    = ST_ALLOCATED;
                     end
                  end
                  default: begin
                     res_status_in = ST_IGNORED;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (ret_ctl.valid) begin
               state_in = S_DONE;
               if (ret_ctl.op == OP_GET) begin
                  if (!ret_ctl.hit) begin
                     res_status_in = ST_NONEXISTENT;
                  end else if (ret_ctl.hit_set) begin
                     res_status_in = ST_RETURNED;
                     res_value_in  = ret_hval;
                  end else begin
                     res_status_in = ST_NOT_SET;
                  end
               end else if (ret_ctl.hit && ret_ctl.hit_set && (ret_ctl.op == OP_GOS)) begin
                  res_status_in = ST_RETURNED;
                  res_value_in  = ret_hval;
               end else if (ret_ctl.hit) begin
                  res_status_in = ST_STORED;
                  res_value_in  = ret_val;
               end else if (ret_key[KEY_BITS-1]) begin
                  res_status_in = ST_TOO_LARGE;
               end else if (full) begin
                  res_status_in = ST_FULL;
               end else begin
                  bc_ctl_in.wr_en  = 1'b1;
                  bc_ctl_in.wr_set = 1'b1;
                  bc_idx_in        = count_ff;
                  bc_key_in        = ret_key;
                  bc_val_in        = ret_val;
                  count_in         = count_ff + 1'b1;
                  res_status_in    = ST_STORED;
                  res_value_in     = ret_val;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_key_in    = res_key_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_key_ff  <= '1;
         wave_ctl_ff  <= '0;
         bc_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_key_ff  <= next_key_in;
         wave_ctl_ff  <= wave_ctl_in;
         bc_ctl_ff    <= bc_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wave_key_ff   <= wave_key_in;
      wave_val_ff   <= wave_val_in;
      bc_idx_ff     <= bc_idx_in;
      bc_key_ff     <= bc_key_in;
      bc_val_ff     <= bc_val_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_key_ff    <= res_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign wave_ctl   = wave_ctl_ff;
   assign wave_key   = wave_key_ff;
   assign wave_val   = wave_val_ff;
   assign count      = count_ff;
   assign bc_ctl     = bc_ctl_ff;
   assign bc_idx     = bc_idx_ff;
   assign bc_key     = bc_key_ff;
   assign bc_val     = bc_val_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_key_ff, rsp_value_ff, rsp_status_ff};

endmodule

// ===== hdl/keyed_reference_value_table.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// keyed_reference_value_table
// Fully associative key/value table with set flags, built as a row of cells.
// -----------------------------------------------------------------------------
// One request beat at a time, one response beat each. Get, set and get-or-set
// with a nonzero key send a search beat down the row of ENTRIES cells, one
// cell per cycle; the matching cell updates itself as the beat passes and an
// append lands in the first free cell when the beat leaves the row. Clear,
// allocate, zero keys and unknown codes skip the search and go straight to
// the result register. Table storage needs no clearing pass after reset. A
// finished response waits in its own register, so the next request is taken
// while it is still held.
// -----------------------------------------------------------------------------
module keyed_reference_value_table
   import kvt_pkg::*;
#(
   parameter int ENTRIES  = 64,
   parameter int KEY_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,   // operation, ref_key, phase_value
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata    // status, value_out, key_out
);

   localparam int CW = $clog2(ENTRIES + 1);

   wave_ctl_type          w_ctl  [ENTRIES+1];
   logic [KEY_BITS-1:0]   w_key  [ENTRIES+1];
   logic [VALUE_BITS-1:0] w_val  [ENTRIES+1];
   logic [VALUE_BITS-1:0] w_hval [ENTRIES+1];
   logic [CW-1:0]         count;
   bcast_ctl_type         bc_ctl;
   logic [CW-1:0]         bc_idx;
   logic [KEY_BITS-1:0]   bc_key;
   logic [VALUE_BITS-1:0] bc_val;

   assign w_hval[0] = '0;

   kvt_ctrl #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .CW       (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .wave_ctl   (w_ctl[0]),
      .wave_key   (w_key[0]),
      .wave_val   (w_val[0]),
      .ret_ctl    (w_ctl[ENTRIES]),
      .ret_key    (w_key[ENTRIES]),
      .ret_val    (w_val[ENTRIES]),
      .ret_hval   (w_hval[ENTRIES]),
      .count      (count),
      .bc_ctl     (bc_ctl),
      .bc_idx     (bc_idx),
      .bc_key     (bc_key),
      .bc_val     (bc_val)
   );

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      kvt_cell #(
         .KEY_BITS (KEY_BITS),
         .CW       (CW),
         .IDX      (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_ctl   (w_ctl[i]),
         .in_key   (w_key[i]),
         .in_val   (w_val[i]),
         .in_hval  (w_hval[i]),
         .out_ctl  (w_ctl[i+1]),
         .out_key  (w_key[i+1]),
         .out_val  (w_val[i+1]),
         .out_hval (w_hval[i+1]),
         .count    (count),
         .bc_ctl   (bc_ctl),
         .bc_idx   (bc_idx),
         .bc_key   (bc_key),
         .bc_val   (bc_val)
      );
   end

endmodule

// ===== bench/keyed_reference_value_table_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// keyed_reference_value_table_tb
// Stream-level test of the keyed reference value table.
// -----------------------------------------------------------------------------
// Requests come from a queue that is filled once. The queue starts with a
// directed list that covers zero keys, unused codes, the largest user key,
// oversized keys, allocation, clear and get-or-set. A random mix follows that
// draws most keys from a small pool, so lookups hit, and fills the table
// until it reports full. The sender runs in bursts with gaps. The receiver
// stalls on a pattern of its own and, once, holds off long enough that the
// input stalls. Each response beat is checked field by field against a
// table model that is updated in the order in which requests are accepted.
// -----------------------------------------------------------------------------
module keyed_reference_value_table_tb;
   import kvt_pkg::*;

   localparam int          ENTRIES        = 64;
   localparam int          KEY_BITS       = 32;
   localparam logic [31:0] KEY_ALL_ONES   = 32'hFFFF_FFFF;
   localparam logic [31:0] KEY_LIMIT      = KEY_ALL_ONES >> 1;
   localparam logic [2:0]  OP_UNUSED_LO   = 3'd5;
   localparam logic [2:0]  OP_UNUSED_HI   = 3'd7;
   localparam int          RANDOM_COUNT   = 500;
   localparam int          KEY_POOL       = 48;
   localparam int          IDLE_LIMIT     = 4000;
   localparam int          HOLD_CYCLES    = 600;
   localparam int          HOLD_AFTER     = 120;
   localparam int          DRAIN_CYCLES   = 100;
   localparam int          REPORT_LIMIT   = 10;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] key;
      logic [63:0] val;
   } lookup_type;

   typedef struct {
      logic [3:0]  status;
      logic [63:0] value;
      logic [31:0] key;
   } reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;   // operation, ref_key, phase_value
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;         // status, value_out, key_out

   keyed_reference_value_table #(
      .ENTRIES (ENTRIES),
      .KEY_BITS(KEY_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   // table model
   logic [31:0] tbl_key [ENTRIES];
   logic [63:0] tbl_val [ENTRIES];
   bit          tbl_set [ENTRIES];
   int          tbl_count = 0;
   logic [31:0] auto_key  = KEY_ALL_ONES;

   lookup_type  table_requests[$];
   reply_type   predicted_replies[$];
   lookup_type  offered;
   bit          req_taken = 1'b0;
   int          accepted_requests = 0;
   int          fault_count = 0;
   int          idle_cycles = 0;

   function automatic int find_entry(logic [31:0] key);
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic logic [3:0] store_entry(logic [31:0] key, logic [63:0] val);
      int idx;
      idx = find_entry(key);
      if (idx >= 0) begin
         tbl_val[idx] = val;
         tbl_set[idx] = 1'b1;
         return ST_STORED;
      end
      if (key > KEY_LIMIT) return ST_TOO_LARGE;
      if (tbl_count >= ENTRIES) return ST_FULL;
      tbl_key[tbl_count] = key;
      tbl_val[tbl_count] = val;
      tbl_set[tbl_count] = 1'b1;
      tbl_count++;
      return ST_STORED;
   endfunction

   function automatic reply_type table_answer(lookup_type q);
      reply_type a;
      int        idx;
      a.status = ST_IGNORED;
      a.value  = '0;
      a.key    = '0;
      case (q.op)
         OP_GET: if (q.key != 0) begin
            idx = find_entry(q.key);
            if (idx < 0) a.status = ST_NONEXISTENT;
            else if (tbl_set[idx]) begin
               a.status = ST_RETURNED;
               a.value  = tbl_val[idx];
            end else a.status = ST_NOT_SET;
         end
         OP_SET: if (q.key != 0) begin
            a.status = store_entry(q.key, q.val);
            if (a.status == ST_STORED) a.value = q.val;
         end
         OP_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) tbl_set[i] = 1'b0;
            a.status = ST_CLEARED;
         end
         OP_ALLOC: begin
            if (tbl_count >= ENTRIES || auto_key <= KEY_LIMIT) a.status = ST_FULL;
            else begin
               tbl_key[tbl_count] = auto_key;
               tbl_val[tbl_count] = '0;
               tbl_set[tbl_count] = 1'b0;
               tbl_count++;
               a.key    = auto_key;
               auto_key = auto_key - 1'b1;
               a.status = ST_ALLOCATED;
            end
         end
         OP_GOS: begin
            if (q.key == 0) a.value = q.val;
            else begin
               idx = find_entry(q.key);
               if (idx >= 0 && tbl_set[idx]) begin
                  a.status = ST_RETURNED;
                  a.value  = tbl_val[idx];
               end else begin
                  a.status = store_entry(q.key, q.val);
                  if (a.status == ST_STORED) a.value = q.val;
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic add_lookup(logic [2:0] op, logic [31:0] key, logic [63:0] val);
      lookup_type q;
      q.op  = op;
      q.key = key;
      q.val = val;
      table_requests.push_back(q);
   endtask

   task automatic report_fault(string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
   endtask

   function automatic logic [63:0] random_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [31:0] random_key();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 32'($urandom_range(1, KEY_POOL));
      if (pick < 78) return '0;
      if (pick < 90) return $urandom();
      return $urandom() & KEY_LIMIT;
   endfunction

   task automatic add_random_lookup();
      int          pick;
      logic [2:0]  op;
      pick = $urandom_range(0, 99);
      if (pick < 32)      op = OP_GET;
      else if (pick < 58) op = OP_SET;
      else if (pick < 62) op = OP_CLEAR;
      else if (pick < 68) op = OP_ALLOC;
      else if (pick < 96) op = OP_GOS;
      else                op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      add_lookup(op, random_key(), random_value());
   endtask

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (table_requests.size() > 0) begin
            offered    = table_requests.pop_front();
            req_tdata  <= REQ_BITS'({offered.val, offered.key, offered.op});
            req_tvalid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end else burst_left--;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern plus one long hold-off
   int  segment_left = 0;
   int  stall_mode   = 0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;
   int  phase_count  = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_done && accepted_requests >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (segment_left == 0) begin
            segment_left = $urandom_range(20, 200);
            stall_mode   = $urandom_range(0, 3);
         end else segment_left--;
         phase_count++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (phase_count % 3) != 0;
               default: rsp_tready <= $urandom_range(0, 7) == 0;
            endcase
         end
      end
   end

   // monitor: check responses, predict accepted requests
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[3:0];
            got.value  = rsp_tdata[67:4];
            got.key    = rsp_tdata[99:68];
            if (predicted_replies.size() == 0) begin
               report_fault($sformatf("unexpected beat status %0d value %h key %h",
                                      got.status, got.value, got.key));
            end else begin
               want = predicted_replies.pop_front();
               if (got.status != want.status || got.value != want.value ||
                   got.key != want.key) begin
                  report_fault($sformatf(
                     "expected status %0d value %h key %h, got status %0d value %h key %h",
                     want.status, want.value, want.key, got.status, got.value, got.key));
               end
            end
         end
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            predicted_replies.push_back(table_answer(offered));
            accepted_requests++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      add_lookup(OP_GET, '0, random_value());
      add_lookup(OP_SET, '0, random_value());
      add_lookup(OP_GOS, '0, '1);
      for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++) add_lookup(3'(c), $urandom(), '1);
      add_lookup(OP_GET, 32'd1, '0);
      add_lookup(OP_SET, 32'd1, '0);
      add_lookup(OP_GET, 32'd1, '1);
      add_lookup(OP_SET, KEY_LIMIT, '1);
      add_lookup(OP_GET, KEY_LIMIT, '0);
      add_lookup(OP_SET, KEY_LIMIT + 1'b1, '1);
      add_lookup(OP_GOS, KEY_ALL_ONES, '1);
      add_lookup(OP_ALLOC, '0, '0);
      add_lookup(OP_GET, KEY_ALL_ONES, '0);
      add_lookup(OP_GOS, KEY_ALL_ONES, v);
      add_lookup(OP_GOS, KEY_ALL_ONES, ~v);
      add_lookup(OP_CLEAR, KEY_ALL_ONES, '1);
      add_lookup(OP_GET, 32'd1, '0);
      add_lookup(OP_GOS, 32'd1, ~v);
      add_lookup(OP_SET, KEY_ALL_ONES, '0);
      add_lookup(OP_ALLOC, '1, '1);
      add_lookup(OP_GET, 32'd2, '0);
      for (int n = 0; n < RANDOM_COUNT; n++) add_random_lookup();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (table_requests.size() > 0 || req_tvalid || predicted_replies.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_replies.size() > 0) report_fault("responses missing at end of run");
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
